[sv/sc2a_pkg.sv]
// shared types, constants and the set-1 make code lookup table
package sc2a_pkg;

  // default ring buffer depth
  localparam int unsigned DEFAULT_BUFFER_DEPTH = 256;

  // key release flag inside a scancode byte
  localparam logic [7:0] RELEASE_BIT = 8'h80;

  // lookup table size constant; the table below covers 46 make codes
  localparam int unsigned TABLE_SIZE = 58;

  // operation selector carried on the input tuser
  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  // unshifted set-1 make code to ascii, zero where no character exists
  function automatic logic [6:0] make_to_ascii(input logic [7:0] code);
    logic [6:0] ch;
    case (code)
      8'h02: ch = 7'h31; // 1
      8'h03: ch = 7'h32;
      8'h04: ch = 7'h33;
      8'h05: ch = 7'h34;
      8'h06: ch = 7'h35;
      8'h07: ch = 7'h36;
      8'h08: ch = 7'h37;
      8'h09: ch = 7'h38;
      8'h0A: ch = 7'h39;
      8'h0B: ch = 7'h30; // 0
      8'h0C: ch = 7'h2D; // -
      8'h0D: ch = 7'h3D; // =
      8'h10: ch = 7'h71; // q
      8'h11: ch = 7'h77;
      8'h12: ch = 7'h65;
      8'h13: ch = 7'h72;
      8'h14: ch = 7'h74;
      8'h15: ch = 7'h79;
      8'h16: ch = 7'h75;
      8'h17: ch = 7'h69;
      8'h18: ch = 7'h6F;
      8'h19: ch = 7'h70; // p
      8'h1A: ch = 7'h5B; // [
      8'h1B: ch = 7'h5D; // ]
      8'h1E: ch = 7'h61; // a
      8'h1F: ch = 7'h73;
      8'h20: ch = 7'h64;
      8'h21: ch = 7'h66;
      8'h22: ch = 7'h67;
      8'h23: ch = 7'h68;
      8'h24: ch = 7'h6A;
      8'h25: ch = 7'h6B;
      8'h26: ch = 7'h6C; // l
      8'h27: ch = 7'h3B; // ;
      8'h2C: ch = 7'h7A; // z
      8'h2D: ch = 7'h78;
      8'h2E: ch = 7'h63;
      8'h2F: ch = 7'h76;
      8'h30: ch = 7'h62;
      8'h31: ch = 7'h6E;
      8'h32: ch = 7'h6D; // m
      8'h33: ch = 7'h2C; // ,
      8'h34: ch = 7'h2E; // .
      8'h35: ch = 7'h2F; // /
      8'h37: ch = 7'h2A; // keypad *
      8'h39: ch = 7'h20; // space
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

[sv/scancode_to_ascii_fifo.sv]
// scancode to ascii translator with a ring buffer of characters
// a read word gives its result word in the cycle after acceptance
// throughput: one input word per cycle; the output register is refilled
//   in the cycle it is taken, so only a stalled result holds the input
// events produce no result word; the buffer holds BUFFER_DEPTH - 1 characters
// reset: synchronous active low, clears both pointers and the output valid
//   flag; buffer contents are not cleared, no reset sweep is needed
module scancode_to_ascii_fifo #(
  parameter int unsigned BUFFER_DEPTH = sc2a_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] scancode
  input  logic       in_tuser,   // [0] op
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] character, [7] zero fill
  output logic       out_tuser   // [0] data_valid
);
  import sc2a_pkg::*;

  localparam int unsigned PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

  logic [6:0]       mem [BUFFER_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [PTR_W-1:0] wptr_inc, rptr_inc;
  logic [6:0]       rd_data_r;
  logic             out_valid_r, out_valid_nxt;
  logic             data_valid_r;

  logic             in_acc;
  logic             is_read;
  logic             is_event;
  logic [6:0]       ch;
  logic             empty;
  logic             full;
  logic             wr_en;
  logic             rd_en;

  // input handshake: accept whenever the result register is free or emptying
  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign is_read   = (op_t'(in_tuser) == OP_READ);
  assign is_event  = (op_t'(in_tuser) == OP_EVENT);

  // pointer increments with wrap at the buffer depth
  assign wptr_inc = (wptr_r == PTR_LAST) ? '0 : wptr_r + PTR_W'(1);
  assign rptr_inc = (rptr_r == PTR_LAST) ? '0 : rptr_r + PTR_W'(1);
  assign empty    = (wptr_r == rptr_r);
  assign full     = (wptr_inc == rptr_r);

  // translation and buffer control
  always_comb begin
    ch = make_to_ascii(in_tdata);
    if ((in_tdata & RELEASE_BIT) != 8'h00) begin
      ch = 7'h00;
    end
    wr_en    = in_acc && is_event && (ch != 7'h00) && !full;
    rd_en    = in_acc && is_read && !empty;
    wptr_nxt = wr_en ? wptr_inc : wptr_r;
    rptr_nxt = rd_en ? rptr_inc : rptr_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc && is_read) begin
      out_valid_nxt = 1'b1;
    end
  end

  // pointers and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r      <= '0;
      rptr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wptr_r      <= wptr_nxt;
      rptr_r      <= rptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // character store, write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr_r] <= ch;
    end
  end

  // character store, registered read port and result flag
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rptr_r];
    end
    if (in_acc && is_read) begin
      data_valid_r <= !empty;
    end
  end

  // result word
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, (data_valid_r ? rd_data_r : 7'h00)};
  assign out_tuser  = data_valid_r;

`ifndef ASSERT_OFF
  // a read on an empty buffer answers with an invalid word
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_read && empty) |=> (out_tvalid && !out_tuser))
    else $error("empty read did not give an invalid result");

  // a read on a nonempty buffer answers with a valid word and advances
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_read && !empty) |=> (out_tvalid && out_tuser && rptr_r != $past(rptr_r)))
    else $error("pop did not advance read pointer");

  // key release never touches the buffer
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_event && in_tdata[7]) |=> $stable(wptr_r))
    else $error("release code changed write pointer");

  // events never produce a result word
  a_event_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_event && !(out_valid_r && !out_tready)) |=> !out_tvalid)
    else $error("event produced a result");

  // a write never makes the buffer look empty
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (wptr_r != rptr_r))
    else $error("write overran the read pointer");
`endif

endmodule
